// ----- design/cptm_pkg.sv -----
// Shared types and constants for the color palette tolerance mapper.
package cptm_pkg;

  // Operation codes carried in the request.
  localparam logic [1:0] FUNC_LEARN = 2'd0;
  localparam logic [1:0] FUNC_MAP   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  // Tolerance after reset.
  localparam logic [7:0] TOLERANCE_RESET = 8'd20;

  // One RGB888 color as held in the palette.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

  // Input request: operation and pixel.
  typedef struct packed {
    logic [1:0] func;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } req_t;

  // Result of one request.
  typedef struct packed {
    logic [3:0] color_index;
    logic       hit;
    logic       overflow;
    logic [4:0] entries_used;
  } rsp_t;

  // Palette update command from the decision logic.
  typedef struct packed {
    logic   insert;
    logic   clear;
    color_t color;
  } upd_t;

endpackage

// ----- design/cptm_match.sv -----
// Parallel tolerance comparators over the palette with a first-match priority encoder.
module cptm_match #(
  parameter int DEPTH = 16,
  parameter int IDX_W = $clog2(DEPTH),
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  cptm_pkg::color_t entries [DEPTH],
  input  logic [CNT_W-1:0] count,
  input  logic [7:0]       tolerance,
  input  cptm_pkg::color_t color,
  output logic             found,
  output logic [IDX_W-1:0] index
);

  logic [DEPTH-1:0] lane_hit;

  // True when two channel values differ by at most the tolerance.
  function automatic logic chan_close(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] tol);
    logic [7:0] diff;
    diff = (a >= b) ? (a - b) : (b - a);
    return diff <= tol;
  endfunction

  // One comparator per entry; only entries below the fill count take part.
  for (genvar i = 0; i < DEPTH; i++) begin : g_lane
    assign lane_hit[i] = (CNT_W'(i) < count) &&
                         chan_close(entries[i].red,   color.red,   tolerance) &&
                         chan_close(entries[i].green, color.green, tolerance) &&
                         chan_close(entries[i].blue,  color.blue,  tolerance);
  end

  // The lowest matching index wins.
  always_comb begin
    found = 1'b0;
    index = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (lane_hit[i]) begin
        found = 1'b1;
        index = IDX_W'(i);
      end
    end
  end

endmodule

// ----- design/cptm_palette.sv -----
// Palette storage and fill count, updated by append and clear commands.
module cptm_palette #(
  parameter int DEPTH = 16,
  parameter int IDX_W = $clog2(DEPTH),
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             update,
  input  cptm_pkg::upd_t   cmd,
  output cptm_pkg::color_t entries [DEPTH],
  output logic [CNT_W-1:0] count
);

  cptm_pkg::color_t colors [DEPTH];

  // Append the new color at the current fill position.
  always_ff @(posedge clk) begin
    if (update && cmd.insert) begin
      colors[count[IDX_W-1:0]] <= cmd.color;
    end
  end

  // Fill count: cleared by reset or a clear request, bumped by an append.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (update) begin
      if (cmd.clear) begin
        count <= '0;
      end else if (cmd.insert) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  assign entries = colors;

endmodule

// ----- design/color_palette_tolerance_mapper.sv -----
// Top level of the color palette tolerance mapper.
// Accepts one request per cycle while no receiver stall holds the result register, and
// returns one result per request: the request is registered, compared against every
// palette entry at once by one tolerance comparator per entry, and the result is
// registered at the same edge that writes any new entry, so the next request already
// sees it. A learn request appends an unmatched color while the palette has room, a
// map request only looks up, and a clear request empties the palette. The tolerance
// register should be written only while no request is in flight.
module color_palette_tolerance_mapper #(
  parameter int PALETTE_DEPTH = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write,
  input  logic [7:0]      cfg_data,
  input  logic            req_valid,
  output logic            req_stall,
  input  cptm_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output cptm_pkg::rsp_t  rsp
);

  localparam int IDX_W = $clog2(PALETTE_DEPTH);
  localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);

  logic             s1_valid;
  cptm_pkg::req_t   s1_req;
  logic [7:0]       tolerance;
  logic             advance;
  logic             fire;
  cptm_pkg::color_t color;
  cptm_pkg::color_t entries [PALETTE_DEPTH];
  logic [CNT_W-1:0] count;
  logic             found;
  logic [IDX_W-1:0] match_index;
  logic             full;
  cptm_pkg::upd_t   cmd;
  cptm_pkg::rsp_t   rsp_next;

  // Tolerance register.
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= cptm_pkg::TOLERANCE_RESET;
    end else if (cfg_write) begin
      tolerance <= cfg_data;
    end
  end

  // Handshake: the result register moves when empty or taken.
  assign advance   = !rsp_valid || !rsp_stall;
  assign req_stall = s1_valid && !advance;
  assign fire      = s1_valid && advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!req_stall) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall && req_valid) begin
      s1_req <= req;
    end
  end

  assign color = '{red: s1_req.red, green: s1_req.green, blue: s1_req.blue};

  cptm_match #(
    .DEPTH(PALETTE_DEPTH),
    .IDX_W(IDX_W),
    .CNT_W(CNT_W)
  ) u_match (
    .entries  (entries),
    .count    (count),
    .tolerance(tolerance),
    .color    (color),
    .found    (found),
    .index    (match_index)
  );

  cptm_palette #(
    .DEPTH(PALETTE_DEPTH),
    .IDX_W(IDX_W),
    .CNT_W(CNT_W)
  ) u_palette (
    .clk    (clk),
    .rst    (rst),
    .update (fire),
    .cmd    (cmd),
    .entries(entries),
    .count  (count)
  );

  assign full = (count == CNT_W'(PALETTE_DEPTH));

  // Decide the palette update and the result for the registered request.
  always_comb begin
    cmd.insert            = 1'b0;
    cmd.clear             = 1'b0;
    cmd.color             = color;
    rsp_next.color_index  = '0;
    rsp_next.hit          = 1'b0;
    rsp_next.overflow     = 1'b0;
    rsp_next.entries_used = 5'(count);
    unique case (s1_req.func)
      cptm_pkg::FUNC_LEARN, cptm_pkg::FUNC_MAP: begin
        if (found) begin
          rsp_next.color_index = 4'(match_index);
          rsp_next.hit         = 1'b1;
        end else if (s1_req.func == cptm_pkg::FUNC_LEARN && !full) begin
          cmd.insert            = 1'b1;
          rsp_next.color_index  = 4'(count[IDX_W-1:0]);
          rsp_next.entries_used = 5'(count + CNT_W'(1));
        end else begin
          rsp_next.overflow = 1'b1;
        end
      end
      cptm_pkg::FUNC_CLEAR: begin
        cmd.clear             = 1'b1;
        rsp_next.entries_used = '0;
      end
      default: begin
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp <= rsp_next;
    end
  end

  // A result never reports a match and an overflow together.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.hit && rsp.overflow))
    else $error("result has both hit and overflow set");

  // The fill count never exceeds the palette depth.
  assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(PALETTE_DEPTH))
    else $error("palette count beyond depth");

  // The fill count grows by at most one entry per cycle.
  assert property (@(posedge clk) disable iff (rst)
    (count > $past(count)) |-> (count == $past(count) + CNT_W'(1)))
    else $error("palette count grew by more than one");

  // The count changes only when a request is processed.
  assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(count))
    else $error("palette count changed without a request");

endmodule

// ----- bench/tb_color_palette_tolerance_mapper.sv -----
// Self-checking testbench for the color palette tolerance mapper.
module tb_color_palette_tolerance_mapper;

  // The request field allows a fourth code that the block must ignore.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int PALETTE_SIZE = 16;
  localparam int MAX_WAIT = 18;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [7:0] cfg_data;
  logic req_valid;
  logic req_stall;
  cptm_pkg::req_t req;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  cptm_pkg::rsp_t rsp;

  // Palette as the block should hold it, updated at each accepted request.
  cptm_pkg::color_t pal_colors [PALETTE_SIZE];
  int pal_count;
  logic [7:0] tol_setting;

  cptm_pkg::rsp_t pending_results [$];
  int mismatches;
  int results_checked;
  int hits_seen;
  int overflows_seen;
  int inserts_seen;
  int clears_seen;
  int tol_writes;
  int cycle_count;
  bit idle_on;
  bit rsp_hold;
  int rsp_wait_left;
  event start_hold;

  color_palette_tolerance_mapper #(
    .PALETTE_DEPTH(PALETTE_SIZE)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  // Clock with a period of 10.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding.", cycle_count,
               pending_results.size());
      $display("color_palette_tolerance_mapper test failed");
      $finish;
    end
  end

  // True when every channel of the entry lies within the tolerance of the pixel.
  function automatic bit within_tolerance(cptm_pkg::color_t entry, cptm_pkg::req_t pix);
    int dr, dg, db;
    dr = int'(entry.red) - int'(pix.red);
    dg = int'(entry.green) - int'(pix.green);
    db = int'(entry.blue) - int'(pix.blue);
    if (dr < 0) dr = -dr;
    if (dg < 0) dg = -dg;
    if (db < 0) db = -db;
    return dr <= int'(tol_setting) && dg <= int'(tol_setting) && db <= int'(tol_setting);
  endfunction

  // Applies one request to the palette and returns the result it should produce.
  function automatic cptm_pkg::rsp_t palette_lookup(cptm_pkg::req_t r);
    cptm_pkg::rsp_t res;
    int found;
    res = '0;
    found = -1;
    if (r.func == cptm_pkg::FUNC_LEARN || r.func == cptm_pkg::FUNC_MAP) begin
      for (int i = 0; i < pal_count; i++) begin
        if (found < 0 && within_tolerance(pal_colors[i], r)) found = i;
      end
      if (found >= 0) begin
        res.color_index = found[3:0];
        res.hit = 1'b1;
        hits_seen++;
      end else if (r.func == cptm_pkg::FUNC_LEARN && pal_count < PALETTE_SIZE) begin
        res.color_index = pal_count[3:0];
        pal_colors[pal_count] = '{red: r.red, green: r.green, blue: r.blue};
        pal_count++;
        inserts_seen++;
      end else begin
        res.overflow = 1'b1;
        overflows_seen++;
      end
    end else if (r.func == cptm_pkg::FUNC_CLEAR) begin
      pal_count = 0;
      clears_seen++;
    end
    res.entries_used = pal_count[4:0];
    return res;
  endfunction

  // Long receiver hold-off, started from a test task.
  initial begin
    rsp_hold <= 1'b0;
    forever begin
      @(start_hold);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      rsp_hold <= 1'b0;
    end
  end

  // Result checker and receiver stall control.
  always @(posedge clk) begin
    cptm_pkg::rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("Unexpected result: index %0d hit %0b overflow %0b used %0d",
                   rsp.color_index, rsp.hit, rsp.overflow, rsp.entries_used);
      end else begin
        want = pending_results.pop_front();
        if (rsp.color_index !== want.color_index || rsp.hit !== want.hit ||
            rsp.overflow !== want.overflow || rsp.entries_used !== want.entries_used) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("Mismatch on result %0d: expected index %0d hit %0b overflow %0b used %0d",
                     results_checked, want.color_index, want.hit, want.overflow,
                     want.entries_used);
            $display("  got index %0d hit %0b overflow %0b used %0d",
                     rsp.color_index, rsp.hit, rsp.overflow, rsp.entries_used);
          end
        end
      end
      rsp_wait_left = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
    end else if (rsp_valid && rsp_wait_left > 0) begin
      rsp_wait_left--;
    end
    rsp_stall <= rsp_hold || (rsp_wait_left > 0);
  end

  // Sends one request, after a random gap while idling is on, and records its expected result.
  task automatic send_request(logic [1:0] func, logic [7:0] red, logic [7:0] green,
                              logic [7:0] blue);
    int gap;
    cptm_pkg::req_t item;
    gap = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
    item = '{func: func, red: red, green: green, blue: blue};
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pending_results = {pending_results, palette_lookup(item)};
  endtask

  // Stops sending and waits until every expected result has come back.
  task automatic wait_drained();
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes the tolerance register while the block is idle.
  task automatic set_tolerance(logic [7:0] value);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    tol_setting = value;
    tol_writes++;
  endtask

  // Moves a channel by up to the given amount either way, clamped to 0..255.
  function automatic logic [7:0] nudge(logic [7:0] chan, int spread);
    int v;
    v = int'(chan) + $urandom_range(0, 2 * spread) - spread;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // Every operation and the exact tolerance edge at the reset setting.
  task automatic test_basic_ops();
    send_request(cptm_pkg::FUNC_LEARN, 8'd0, 8'd0, 8'd0);
    send_request(cptm_pkg::FUNC_LEARN, 8'd20, 8'd20, 8'd20);
    send_request(cptm_pkg::FUNC_LEARN, 8'd21, 8'd0, 8'd0);
    send_request(cptm_pkg::FUNC_MAP, 8'd255, 8'd255, 8'd255);
    send_request(cptm_pkg::FUNC_LEARN, 8'd255, 8'd255, 8'd255);
    send_request(cptm_pkg::FUNC_MAP, 8'd235, 8'd235, 8'd235);
    send_request(FUNC_UNUSED, 8'd170, 8'd85, 8'd170);
    send_request(cptm_pkg::FUNC_CLEAR, 8'd85, 8'd170, 8'd85);
    send_request(cptm_pkg::FUNC_MAP, 8'd0, 8'd0, 8'd0);
  endtask

  // Fills the palette at zero tolerance, then learns one color too many.
  task automatic test_palette_full();
    set_tolerance(8'd0);
    for (int i = 0; i < PALETTE_SIZE; i++)
      send_request(cptm_pkg::FUNC_LEARN, 8'(i * 17), 8'(255 - i * 17), 8'(i * 16 + 1));
    send_request(cptm_pkg::FUNC_LEARN, 8'd1, 8'd2, 8'd3);
    send_request(cptm_pkg::FUNC_LEARN, 8'd255, 8'd0, 8'd241);
    send_request(cptm_pkg::FUNC_MAP, 8'd1, 8'd255, 8'd1);
  endtask

  // Draws one request: mostly pixels near stored or common colors.
  task automatic send_random_request();
    int pick;
    int spread;
    logic [1:0] func;
    cptm_pkg::color_t base;
    pick = $urandom_range(0, 99);
    if (pick < 63) func = cptm_pkg::FUNC_LEARN;
    else if (pick < 93) func = cptm_pkg::FUNC_MAP;
    else if (pick < 96) func = cptm_pkg::FUNC_CLEAR;
    else func = FUNC_UNUSED;
    spread = (int'(tol_setting) < 40) ? int'(tol_setting) + 2 : 42;
    pick = $urandom_range(0, 9);
    if (pick < 5 && pal_count > 0) begin
      base = pal_colors[$urandom_range(0, pal_count - 1)];
    end else if (pick < 8) begin
      base.red = 8'($urandom_range(0, 3) * 85);
      base.green = 8'($urandom_range(0, 3) * 85);
      base.blue = 8'($urandom_range(0, 3) * 85);
    end else begin
      base = cptm_pkg::color_t'(24'($urandom));
      spread = 0;
    end
    send_request(func, nudge(base.red, spread), nudge(base.green, spread),
                 nudge(base.blue, spread));
  endtask

  // Receiver holds off long enough for the block to fill and stall its input.
  task automatic test_backpressure();
    set_tolerance(8'd8);
    idle_on = 1'b0;
    -> start_hold;
    repeat (60) send_random_request();
    wait_drained();
    idle_on = 1'b1;
  endtask

  // Random phases across tolerance settings, one of them without idling.
  task automatic test_random_phases();
    logic [7:0] tol;
    for (int phase = 0; phase < 7; phase++) begin
      if (phase == 0) tol = 8'd255;
      else if (phase == 1) tol = 8'd0;
      else if (phase == 3) tol = 8'd1;
      else if ($urandom_range(0, 3) == 0) tol = 8'($urandom_range(0, 255));
      else tol = 8'($urandom_range(0, 40));
      set_tolerance(tol);
      idle_on = (phase != 2);
      repeat (205) send_random_request();
    end
    idle_on = 1'b1;
  endtask

  // Test sequence.
  initial begin
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_data <= '0;
    req_valid <= 1'b0;
    req <= '0;
    idle_on = 1'b1;
    pal_count = 0;
    tol_setting = cptm_pkg::TOLERANCE_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_ops();
    test_palette_full();
    test_backpressure();
    test_random_phases();
    wait_drained();
    repeat (10) @(posedge clk);
    $display("Checked %0d results over %0d tolerance settings in %0d cycles.",
             results_checked, tol_writes + 1, cycle_count);
    $display("Saw %0d hits, %0d inserts, %0d overflows and %0d clears; %0d mismatches.",
             hits_seen, inserts_seen, overflows_seen, clears_seen, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("color_palette_tolerance_mapper test passed");
    end else begin
      $display("color_palette_tolerance_mapper test failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/cptm_pkg.sv
design/cptm_match.sv
design/cptm_palette.sv
design/color_palette_tolerance_mapper.sv
bench/tb_color_palette_tolerance_mapper.sv
